// ----- sv/pale_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional array list engine - shared definitions
// Command and status codes, sequencer states and the control group that
// the top level broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package pale_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 9;
	localparam int OP_W         = 3;
	localparam int STAT_W       = 3;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_WRITE  = 3'd3,
		OP_READ   = 3'd4,
		OP_FIND   = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK          = 3'd0,
		ST_NOT_STARTED = 3'd1,
		ST_EMPTY       = 3'd2,
		ST_BAD_POS     = 3'd3,
		ST_FULL        = 3'd4,
		ST_NOT_FOUND   = 3'd5
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// load: capture compare flags for a new transaction
	// ins/del/wr: apply the update at the end of the execute cycle
	typedef struct packed {
		logic load;
		logic ins;
		logic del;
		logic wr;
	} cell_ctl_t;

endpackage

// ----- sv/pale_cell.sv -----
// ----------------------------------------------------------------------------
// Positional array list engine - storage cell
// Holds one list word, flags a match and its position relative to the
// command, and takes its neighbor's word when the list shifts.
// ----------------------------------------------------------------------------
module pale_cell import pale_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                               clk,
	input  cell_ctl_t                          ctl,
	input  logic [DATA_W-1:0]                  cmp_value,
	input  logic [DATA_W-1:0]                  wr_value,
	input  logic [POS_W-1:0]                   position,
	input  logic [$clog2(CAPACITY+1)-1:0]      count,
	input  logic [DATA_W-1:0]                  left,
	input  logic [DATA_W-1:0]                  right,
	output logic [DATA_W-1:0]                  word,
	output logic                               hit,
	output logic [DATA_W-1:0]                  rd
);

	localparam int CNW = $clog2(CAPACITY + 1);
	localparam int CW  = ((CNW > POS_W) ? CNW : POS_W) + 1;

	logic [CW-1:0]     idx_c;
	logic [DATA_W-1:0] word_q;
	logic              hit_q;
	logic              sel_q;
	logic              above_q;

	assign idx_c = CW'(IDX);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_q   <= (word_q == cmp_value) && (idx_c < CW'(count));
			sel_q   <= ((idx_c + 1'b1) == CW'(position));
			above_q <= ((idx_c + 1'b1) > CW'(position));
		end
		if (ctl.ins) begin
			if (sel_q) begin
				word_q <= wr_value;
			end else if (above_q) begin
				word_q <= left;
			end
		end else if (ctl.del) begin
			if (sel_q || above_q) begin
				word_q <= right;
			end
		end else if (ctl.wr) begin
			if (sel_q) begin
				word_q <= wr_value;
			end
		end
	end

	assign word = word_q;
	assign hit  = hit_q;
	assign rd   = sel_q ? word_q : '0;

endmodule

// ----- sv/pale_first_hit.sv -----
// ----------------------------------------------------------------------------
// Positional array list engine - first match tree
// Pairwise tree that reports whether any cell matched and the index of
// the lowest matching cell.
// ----------------------------------------------------------------------------
module pale_first_hit import pale_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic [CAPACITY-1:0]         hit,
	output logic                        any,
	output logic [$clog2(CAPACITY)-1:0] idx
);

	localparam int IW = $clog2(CAPACITY);
	localparam int P  = 1 << IW;

	logic          nv  [IW+1][P];
	logic [IW-1:0] nix [IW+1][P];

	genvar l, k;
	generate
		for (k = 0; k < P; k++) begin : g_leaf
			if (k < CAPACITY) begin : g_real
				assign nv[0][k] = hit[k];
			end else begin : g_pad
				assign nv[0][k] = 1'b0;
			end
			assign nix[0][k] = IW'(k);
		end
		for (l = 0; l < IW; l++) begin : g_lvl
			for (k = 0; k < P; k++) begin : g_node
				if (k < (P >> (l + 1))) begin : g_used
					// lower half wins when it holds a match
					assign nv[l+1][k]  = nv[l][2*k] | nv[l][2*k+1];
					assign nix[l+1][k] = nv[l][2*k] ? nix[l][2*k] : nix[l][2*k+1];
				end else begin : g_idle
					assign nv[l+1][k]  = 1'b0;
					assign nix[l+1][k] = '0;
				end
			end
		end
	endgenerate

	assign any = nv[IW][0];
	assign idx = nix[IW][0];

endmodule

// ----- sv/positional_array_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// Positional array list engine - top level
// Ordered list of signed words kept in a row of cells, one command per
// transaction.
// ----------------------------------------------------------------------------
// Each command passes through the execute state: busy rises in the cycle
// after start is taken, the cell row updates at the end of the execute
// state, and the result appears on the following cycle with done high for
// exactly one cycle. A new command may be issued in the cycle done is high,
// but is not taken while busy; the execute state is where the match tree
// and the read-out OR across all cells resolve.
// The receiver cannot stall: results must be captured when done is high.
// No clearing pass is needed after reset; the list is empty until started.
module positional_array_list_engine_top import pale_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] data_out,
	output logic [POS_W-1:0]         found_position,
	output logic [POS_W-1:0]         list_length
);

	localparam int IW  = $clog2(CAPACITY);
	localparam int CNW = $clog2(CAPACITY + 1);
	localparam int CW  = ((CNW > POS_W) ? CNW : POS_W) + 1;

	fsm_t              state_q, state_nx;
	logic              accept;
	logic              exec;

	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] value_q;
	logic [CNW-1:0]    count_q;
	logic              started_q;

	logic              done_q;
	status_t           status_q;
	logic [DATA_W-1:0] data_q;
	logic [POS_W-1:0]  found_q;
	logic [POS_W-1:0]  length_q;

	cell_ctl_t         ctl;
	logic [DATA_W-1:0] word_w [CAPACITY];
	logic [DATA_W-1:0] rd_w   [CAPACITY];
	logic [CAPACITY-1:0] hit_w;
	logic [DATA_W-1:0] rd_or;
	logic              hit_any;
	logic [IW-1:0]     hit_idx;

	status_t           st;
	logic              rd_en;
	logic              fnd_en;
	logic              go_ins, go_del, go_wr, go_start;
	logic [CNW-1:0]    cnt_nx;
	logic [CW-1:0]     pos_w, cnt_w;
	logic              ins_pos_ok, pos_ok;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FSM_IDLE: if (start) state_nx = FSM_EXEC;
			FSM_EXEC: state_nx = FSM_IDLE;
			default:  state_nx = FSM_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q == FSM_EXEC);
		exec   = (state_q == FSM_EXEC);
		accept = start && (state_q == FSM_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// hold the command for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			pos_q   <= position;
			value_q <= value;
		end
	end

	// ------------------------------------------------------------------
	// Command decode and status
	// ------------------------------------------------------------------
	assign pos_w      = CW'(pos_q);
	assign cnt_w      = CW'(count_q);
	assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
	assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);

	always_comb begin
		st       = ST_OK;
		rd_en    = 1'b0;
		fnd_en   = 1'b0;
		go_ins   = 1'b0;
		go_del   = 1'b0;
		go_wr    = 1'b0;
		go_start = 1'b0;
		cnt_nx   = count_q;
		unique case (op_q)
			OP_START: begin
				go_start = 1'b1;
				cnt_nx   = '0;
			end
			OP_INSERT: begin
				if (!started_q) begin
					st = ST_NOT_STARTED;
				end else if (!ins_pos_ok) begin
					st = ST_BAD_POS;
				end else if (count_q == CNW'(CAPACITY)) begin
					st = ST_FULL;
				end else begin
					go_ins = 1'b1;
					cnt_nx = count_q + 1'b1;
				end
			end
			OP_FIND: begin
				if (!started_q) begin
					st = ST_NOT_STARTED;
				end else if (count_q == '0) begin
					st = ST_EMPTY;
				end else if (!hit_any) begin
					st = ST_NOT_FOUND;
				end else begin
					fnd_en = 1'b1;
				end
			end
			OP_DELETE, OP_WRITE, OP_READ: begin
				if (!started_q) begin
					st = ST_NOT_STARTED;
				end else if (count_q == '0) begin
					st = ST_EMPTY;
				end else if (!pos_ok) begin
					st = ST_BAD_POS;
				end else if (op_q == OP_DELETE) begin
					rd_en  = 1'b1;
					go_del = 1'b1;
					cnt_nx = count_q - 1'b1;
				end else if (op_q == OP_WRITE) begin
					go_wr = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
	end

	always_comb begin
		ctl.load = accept;
		ctl.ins  = exec && go_ins;
		ctl.del  = exec && go_del;
		ctl.wr   = exec && go_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				count_q <= cnt_nx;
				if (go_start) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= st;
			data_q   <= rd_en ? rd_or : '0;
			found_q  <= fnd_en ? POS_W'(CW'(hit_idx) + 1'b1) : '0;
			length_q <= POS_W'(cnt_nx);
		end
	end

	// ------------------------------------------------------------------
	// Cell row
	// ------------------------------------------------------------------
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_W-1:0] left_w, right_w;
			if (i == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = word_w[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = word_w[i+1];
			end
			pale_cell #(
				.CAPACITY (CAPACITY),
				.IDX      (i)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.cmp_value (value),
				.wr_value  (value_q),
				.position  (position),
				.count     (count_q),
				.left      (left_w),
				.right     (right_w),
				.word      (word_w[i]),
				.hit       (hit_w[i]),
				.rd        (rd_w[i])
			);
		end
	endgenerate

	// only the selected cell drives nonzero read data
	always_comb begin
		rd_or = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			rd_or = rd_or | rd_w[j];
		end
	end

	pale_first_hit #(
		.CAPACITY (CAPACITY)
	) u_first_hit (
		.hit (hit_w),
		.any (hit_any),
		.idx (hit_idx)
	);

	assign done           = done_q;
	assign status         = status_q;
	assign data_out       = data_q;
	assign found_position = found_q;
	assign list_length    = length_q;

endmodule
